### src/sds_pkg.sv
// package for the sub-band dedispersion sum block
// holds field widths, default sizes, the command and register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

    // default sizes for the top-level parameters
    localparam int NUM_CHANNELS_DEF = 1024;
    localparam int RING_DEPTH_DEF   = 512;
    localparam int MAX_BANDS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF  = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // input beat fields
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 9;
    localparam int CHAN_W  = 10;
    localparam int VALUE_W = 16;

    // result beat fields
    localparam int BAND_OUT_W = 4;
    localparam int SUM_W      = 26;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int NB_W       = 5;
    localparam int CPB_REG_W  = 11;
    localparam int RR_W       = 10;

    // channels per band are capped at a fixed maximum
    localparam int CPB_MAX = 1024;
    localparam int CPB_W   = 10;

    // commands carried by an input beat
    typedef enum logic [CMD_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_BANDS = 2'd0,
        CFG_CPB       = 2'd1,
        CFG_RING_ROWS = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

### src/subband_dedispersion_sum.sv
// Sub-band incoherent dedispersion sum. A write beat stores one sample in the spectrum ring,
// a load beat sets one channel's delay and ignore mark, and a compute beat returns one beat
// per sub-band holding the exact sum of that band's non-ignored channels, each read at
// (read row + delay clamped to ring rows - 1) mod ring rows, the last band marked; the read
// row then steps on. A compute issues one channel slot per cycle while no result is held up
// (channels per band for each band, fewer for a band that runs past the last channel, at
// least one), then drains the pipeline; a read row beyond a shrunk ring is first brought
// inside it, one ring length at a time. The single read port of the delay table and of the
// spectrum ring set the one-channel-per-cycle pace. Beats queue in front (four deep) while a
// compute runs. After reset the delay table is cleared, during which no input beat is taken;
// configuration writes are taken at any time.
// Configuration is to be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module subband_dedispersion_sum #(
    parameter int NUM_CHANNELS = sds_pkg::NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = sds_pkg::RING_DEPTH_DEF,
    parameter int MAX_BANDS    = sds_pkg::MAX_BANDS_DEF,
    parameter int SAMPLE_BITS  = sds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sds_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sds_pkg::CMD_W-1:0]         i_command,
    input  logic [sds_pkg::ROW_W-1:0]         i_row,
    input  logic [sds_pkg::CHAN_W-1:0]        i_channel,
    input  logic [sds_pkg::VALUE_W-1:0]       i_value,
    input  logic                              i_ignore_flag,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sds_pkg::BAND_OUT_W-1:0]    o_band,
    output logic [sds_pkg::SUM_W-1:0]         o_band_sum,
    output logic                              o_last
);

    localparam int RA_W    = $clog2(RING_DEPTH);
    localparam int ROWS_W  = $clog2(RING_DEPTH + 1);
    localparam int CH_AW   = $clog2(NUM_CHANNELS);
    localparam int BAND_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int VAL_W   = sds_pkg::VALUE_W;
    localparam int ENTRY_W = sds_pkg::CMD_W + RA_W + CH_AW + VAL_W + 1;
    localparam int VAL_LO  = 1;
    localparam int CH_LO   = VAL_LO + VAL_W;
    localparam int ROW_LO  = CH_LO + CH_AW;
    localparam int OP_LO   = ROW_LO + RA_W;

    logic [sds_pkg::NB_W-1:0]      r_num_bands;
    logic [sds_pkg::CPB_REG_W-1:0] r_cpb;
    logic [sds_pkg::RR_W-1:0]      r_ring_rows;

    logic [ROWS_W-1:0]          w_rows;
    logic [BAND_W-1:0]          w_nbm1;
    logic [sds_pkg::CPB_W-1:0]  w_cpbm1;

    logic                 w_f_push;
    sds_pkg::t_op         w_f_op;
    logic [RA_W-1:0]      w_f_row;
    logic [CH_AW-1:0]     w_f_chan;
    logic [VAL_W-1:0]     w_f_value;
    logic                 w_f_ign;
    logic [ENTRY_W-1:0]   w_f_data;

    logic                 w_q_full;
    logic                 w_q_valid;
    logic [ENTRY_W-1:0]   w_q_data;
    logic                 w_q_pop;
    sds_pkg::t_op         w_q_op;
    logic                 w_clearing;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bands <= sds_pkg::NB_W'(1);
            r_cpb       <= sds_pkg::CPB_REG_W'(sds_pkg::CPB_MAX);
            r_ring_rows <= sds_pkg::RR_W'(512);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sds_pkg::CFG_NUM_BANDS: r_num_bands <= i_cfg_data[sds_pkg::NB_W-1:0];
                sds_pkg::CFG_CPB:       r_cpb       <= i_cfg_data[sds_pkg::CPB_REG_W-1:0];
                sds_pkg::CFG_RING_ROWS: r_ring_rows <= i_cfg_data[sds_pkg::RR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp registers to their working ranges
    always_comb begin
        if (32'(r_ring_rows) < 32'(2)) begin
            w_rows = ROWS_W'(2);
        end else if (32'(r_ring_rows) > 32'(RING_DEPTH)) begin
            w_rows = ROWS_W'(RING_DEPTH);
        end else begin
            w_rows = ROWS_W'(r_ring_rows);
        end

        if (r_num_bands == '0) begin
            w_nbm1 = '0;
        end else if (32'(r_num_bands) > 32'(MAX_BANDS)) begin
            w_nbm1 = BAND_W'(MAX_BANDS - 1);
        end else begin
            w_nbm1 = BAND_W'(r_num_bands - sds_pkg::NB_W'(1));
        end

        if (r_cpb == '0) begin
            w_cpbm1 = '0;
        end else if (32'(r_cpb) > 32'(sds_pkg::CPB_MAX)) begin
            w_cpbm1 = sds_pkg::CPB_W'(sds_pkg::CPB_MAX - 1);
        end else begin
            w_cpbm1 = sds_pkg::CPB_W'(r_cpb - sds_pkg::CPB_REG_W'(1));
        end
    end

    sds_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .RING_DEPTH   (RING_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_row         (i_row),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .i_ignore_flag (i_ignore_flag),
        .i_rows        (w_rows),
        .i_queue_full  (w_q_full),
        .i_clearing    (w_clearing),
        .o_push        (w_f_push),
        .o_op          (w_f_op),
        .o_row         (w_f_row),
        .o_chan        (w_f_chan),
        .o_value       (w_f_value),
        .o_ignore      (w_f_ign)
    );

    // pack a queue entry
    assign w_f_data = {w_f_op, w_f_row, w_f_chan, w_f_value, w_f_ign};

    sds_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (sds_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_data  (w_f_data),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    assign w_q_op = sds_pkg::t_op'(w_q_data[ENTRY_W-1:OP_LO]);

    sds_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .RING_DEPTH   (RING_DEPTH),
        .MAX_BANDS    (MAX_BANDS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_q_op),
        .i_q_row     (w_q_data[OP_LO-1:ROW_LO]),
        .i_q_chan    (w_q_data[ROW_LO-1:CH_LO]),
        .i_q_value   (w_q_data[CH_LO-1:VAL_LO]),
        .i_q_ignore  (w_q_data[0]),
        .o_q_pop     (w_q_pop),
        .i_rows      (w_rows),
        .i_nbm1      (w_nbm1),
        .i_cpbm1     (w_cpbm1),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_band      (o_band),
        .o_band_sum  (o_band_sum),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

### src/sds_front.sv
// front end: takes input beats, range-checks and classifies them
// drops beats that change nothing and clamps delays; uses sds_pkg
`timescale 1ns / 1ps
`default_nettype none

module sds_front #(
    parameter int NUM_CHANNELS = sds_pkg::NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = sds_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS  = sds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sds_pkg::CMD_W-1:0]           i_command,
    input  logic [sds_pkg::ROW_W-1:0]           i_row,
    input  logic [sds_pkg::CHAN_W-1:0]          i_channel,
    input  logic [sds_pkg::VALUE_W-1:0]         i_value,
    input  logic                                i_ignore_flag,
    input  logic [$clog2(RING_DEPTH+1)-1:0]     i_rows,
    input  logic                                i_queue_full,
    input  logic                                i_clearing,
    output logic                                o_push,
    output sds_pkg::t_op                        o_op,
    output logic [$clog2(RING_DEPTH)-1:0]       o_row,
    output logic [$clog2(NUM_CHANNELS)-1:0]     o_chan,
    output logic [sds_pkg::VALUE_W-1:0]         o_value,
    output logic                                o_ignore
);

    localparam int RA_W  = $clog2(RING_DEPTH);
    localparam int CH_AW = $clog2(NUM_CHANNELS);

    logic w_accept;
    logic w_row_ok;
    logic w_chan_ok;
    logic w_keep;

    // hold off while the queue is full or the delay table is being cleared
    assign o_in_stall = i_queue_full || i_clearing;
    assign w_accept   = i_in_valid && !o_in_stall;

    // range checks against the live ring size and the channel count
    assign w_row_ok  = 32'(i_row) < 32'(i_rows);
    assign w_chan_ok = 32'(i_channel) < 32'(NUM_CHANNELS);

    // classify the beat and shape its value
    always_comb begin
        w_keep  = 1'b0;
        o_value = '0;
        case (i_command)
            sds_pkg::OP_WRITE: begin
                w_keep  = w_row_ok && w_chan_ok;
                o_value = sds_pkg::VALUE_W'(i_value[SAMPLE_BITS-1:0]);
            end
            sds_pkg::OP_LOAD: begin
                w_keep = w_chan_ok;
                if (32'(i_value) > 32'(RING_DEPTH - 1)) begin
                    o_value = sds_pkg::VALUE_W'(RING_DEPTH - 1);
                end else begin
                    o_value = i_value;
                end
            end
            sds_pkg::OP_COMPUTE: begin
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_push   = w_accept && w_keep;
    assign o_op     = sds_pkg::t_op'(i_command);
    assign o_row    = RA_W'(i_row);
    assign o_chan   = CH_AW'(i_channel);
    assign o_ignore = i_ignore_flag;

endmodule

`default_nettype wire

### src/sds_queue.sv
// short first-in first-out queue between the front and back ends
// register based, one push and one pop per cycle; no package use
`timescale 1ns / 1ps
`default_nettype none

module sds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = 32'(r_count) == DEPTH;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/sds_back.sv
// back end: executes queued commands against the spectrum ring and delay table
// runs the per-channel summing pipeline and the result register; uses sds_pkg
`timescale 1ns / 1ps
`default_nettype none

module sds_back #(
    parameter int NUM_CHANNELS = sds_pkg::NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = sds_pkg::RING_DEPTH_DEF,
    parameter int MAX_BANDS    = sds_pkg::MAX_BANDS_DEF,
    parameter int SAMPLE_BITS  = sds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_q_valid,
    input  sds_pkg::t_op                                     i_q_op,
    input  logic [$clog2(RING_DEPTH)-1:0]                    i_q_row,
    input  logic [$clog2(NUM_CHANNELS)-1:0]                  i_q_chan,
    input  logic [sds_pkg::VALUE_W-1:0]                      i_q_value,
    input  logic                                             i_q_ignore,
    output logic                                             o_q_pop,
    input  logic [$clog2(RING_DEPTH+1)-1:0]                  i_rows,
    input  logic [(MAX_BANDS > 1 ? $clog2(MAX_BANDS) : 1)-1:0] i_nbm1,
    input  logic [sds_pkg::CPB_W-1:0]                        i_cpbm1,
    output logic                                             o_clearing,
    output logic                                             o_out_valid,
    input  logic                                             i_out_stall,
    output logic [sds_pkg::BAND_OUT_W-1:0]                   o_band,
    output logic [sds_pkg::SUM_W-1:0]                        o_band_sum,
    output logic                                             o_last
);

    localparam int RA_W      = $clog2(RING_DEPTH);
    localparam int CH_AW     = $clog2(NUM_CHANNELS);
    localparam int BAND_W    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CW        = $clog2(MAX_BANDS * sds_pkg::CPB_MAX);
    localparam int RING_WORDS = RING_DEPTH * NUM_CHANNELS;
    localparam int RING_AW   = $clog2(RING_WORDS);
    localparam int DLY_W     = RA_W + 1;
    localparam int SUM_W     = sds_pkg::SUM_W;
    localparam int CPB_W     = sds_pkg::CPB_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // tag that travels with each channel slot down the pipeline
    typedef struct packed {
        logic              valid;
        logic              use_smp;
        logic              bend;
        logic              last;
        logic [BAND_W-1:0] band;
        logic [CH_AW-1:0]  chan;
    } t_tag;

    t_state              r_state;
    logic [CH_AW-1:0]    r_clr_idx;
    logic [RA_W-1:0]     r_read_row;
    logic [RA_W-1:0]     r_base;
    logic [CW-1:0]       r_chan;
    logic [CW-1:0]       r_band_base;
    logic [CPB_W-1:0]    r_k;
    logic [BAND_W-1:0]   r_band;

    t_tag                r_s1;
    t_tag                r_s2;
    t_tag                r_s3;
    logic [RA_W-1:0]     r_s2_row;

    logic [DLY_W-1:0]       r_dly_mem [NUM_CHANNELS];
    logic [DLY_W-1:0]       r_dly_q;
    logic [SAMPLE_BITS-1:0] r_ring_mem [RING_WORDS];
    logic [SAMPLE_BITS-1:0] r_ring_q;

    logic [SUM_W-1:0]                r_acc;
    logic                            r_out_valid;
    logic [sds_pkg::BAND_OUT_W-1:0]  r_out_band;
    logic [SUM_W-1:0]                r_out_sum;
    logic                            r_out_last;

    logic                 w_adv;
    logic                 w_issue;
    logic                 w_in_range;
    logic                 w_bend;
    logic                 w_last;
    logic [CPB_W:0]       w_cpb;
    logic [CW-1:0]        w_next_base;
    logic [RA_W:0]        w_row_inc;
    logic [RA_W-1:0]      w_next_row;
    logic                 w_dly_we;
    logic [CH_AW-1:0]     w_dly_wa;
    logic [DLY_W-1:0]     w_dly_wd;
    logic [CH_AW-1:0]     w_dly_ra;
    logic [RA_W-1:0]      w_dly;
    logic                 w_ign;
    logic [RA_W-1:0]      w_dcl;
    logic [RA_W:0]        w_rsum;
    logic [RA_W-1:0]      w_row;
    logic                 w_ring_we;
    logic [RA_W-1:0]      w_ring_row;
    logic [CH_AW-1:0]     w_ring_chan;
    logic [RING_AW-1:0]   w_ring_addr;
    logic [SUM_W-1:0]     w_sum;
    logic                 w_emit;

    // whole pipeline moves unless a finished result is held up
    assign w_adv = !r_out_valid || !i_out_stall;

    assign o_clearing = r_state == ST_CLEAR;
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;

    // channel slot issue control
    assign w_in_range  = 32'(r_chan) < 32'(NUM_CHANNELS);
    assign w_bend      = (r_k == i_cpbm1) || (32'(r_chan) >= 32'(NUM_CHANNELS - 1));
    assign w_last      = w_bend && (r_band == i_nbm1);
    assign w_issue     = (r_state == ST_ISSUE) && w_adv;
    assign w_cpb       = {1'b0, i_cpbm1} + (CPB_W + 1)'(1);
    assign w_next_base = r_band_base + CW'(w_cpb);

    // read row advance with wrap
    assign w_row_inc  = {1'b0, r_base} + (RA_W + 1)'(1);
    assign w_next_row = (32'(w_row_inc) >= 32'(i_rows)) ? '0 : RA_W'(w_row_inc);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_read_row  <= '0;
            r_base      <= '0;
            r_chan      <= '0;
            r_band_base <= '0;
            r_k         <= '0;
            r_band      <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (32'(r_clr_idx) == NUM_CHANNELS - 1) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + CH_AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (i_q_valid && (i_q_op == sds_pkg::OP_COMPUTE)) begin
                        r_base  <= r_read_row;
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    // bring the read row inside a ring that may have shrunk
                    if (32'(r_base) >= 32'(i_rows)) begin
                        r_base <= RA_W'(32'(r_base) - 32'(i_rows));
                    end else begin
                        r_chan      <= '0;
                        r_band_base <= '0;
                        r_k         <= '0;
                        r_band      <= '0;
                        r_state     <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (w_adv) begin
                        if (w_bend) begin
                            if (r_band == i_nbm1) begin
                                r_read_row <= w_next_row;
                                r_state    <= ST_DRAIN;
                            end else begin
                                r_band      <= r_band + BAND_W'(1);
                                r_band_base <= w_next_base;
                                r_chan      <= w_next_base;
                                r_k         <= '0;
                            end
                        end else begin
                            r_chan <= r_chan + CW'(1);
                            r_k    <= r_k + CPB_W'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1.valid && !r_s2.valid && !r_s3.valid) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // delay table: cleared after reset, loaded from the queue, read per slot
    assign w_dly_we = (r_state == ST_CLEAR) ||
                      ((r_state == ST_IDLE) && i_q_valid && (i_q_op == sds_pkg::OP_LOAD));
    assign w_dly_wa = (r_state == ST_CLEAR) ? r_clr_idx : i_q_chan;
    assign w_dly_wd = (r_state == ST_CLEAR) ? '0 : {i_q_ignore, RA_W'(i_q_value)};
    assign w_dly_ra = w_in_range ? CH_AW'(r_chan) : '0;

    always_ff @(posedge i_clk) begin
        if (w_dly_we) begin
            r_dly_mem[w_dly_wa] <= w_dly_wd;
        end
        if (w_adv) begin
            r_dly_q <= r_dly_mem[w_dly_ra];
        end
    end

    // delayed row: clamp the delay, add the base, wrap once
    assign w_dly  = r_dly_q[RA_W-1:0];
    assign w_ign  = r_dly_q[RA_W];
    assign w_dcl  = (32'(w_dly) >= 32'(i_rows)) ? RA_W'(32'(i_rows) - 1) : w_dly;
    assign w_rsum = {1'b0, r_base} + {1'b0, w_dcl};
    assign w_row  = (32'(w_rsum) >= 32'(i_rows)) ? RA_W'(32'(w_rsum) - 32'(i_rows))
                                                 : RA_W'(w_rsum);

    // spectrum ring: queue writes when idle, pipeline reads otherwise
    assign w_ring_we   = (r_state == ST_IDLE) && i_q_valid && (i_q_op == sds_pkg::OP_WRITE);
    assign w_ring_row  = (r_state == ST_IDLE) ? i_q_row : r_s2_row;
    assign w_ring_chan = (r_state == ST_IDLE) ? i_q_chan : r_s2.chan;
    assign w_ring_addr = RING_AW'(32'(w_ring_row) * 32'(NUM_CHANNELS) + 32'(w_ring_chan));

    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring_mem[w_ring_addr] <= i_q_value[SAMPLE_BITS-1:0];
        end
        if (w_adv) begin
            r_ring_q <= r_ring_mem[w_ring_addr];
        end
    end

    // pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (w_adv) begin
            r_s1.valid   <= w_issue;
            r_s1.use_smp <= w_in_range;
            r_s1.bend    <= w_bend;
            r_s1.last    <= w_last;
            r_s1.band    <= r_band;
            r_s1.chan    <= CH_AW'(r_chan);
            r_s2         <= r_s1;
            r_s2.use_smp <= r_s1.use_smp && !w_ign;
            r_s3         <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_row <= w_row;
        end
    end

    // band accumulator
    assign w_sum  = r_acc + (r_s3.use_smp ? SUM_W'(r_ring_q) : '0);
    assign w_emit = w_adv && r_s3.valid && r_s3.bend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv && r_s3.valid) begin
                r_acc <= r_s3.bend ? '0 : w_sum;
            end
            if (w_adv) begin
                r_out_valid <= r_s3.valid && r_s3.bend;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_band <= sds_pkg::BAND_OUT_W'(r_s3.band);
            r_out_sum  <= w_sum;
            r_out_last <= r_s3.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_band      = r_out_band;
    assign o_band_sum  = r_out_sum;
    assign o_last      = r_out_last;

    // pipeline is empty whenever a new command may be taken
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1.valid && !r_s2.valid && !r_s3.valid))
        else $error("pipeline busy while sequencer idle");

    // the final band only closes once issue has finished
    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3.valid && r_s3.bend && r_s3.last) |-> (r_state == ST_DRAIN))
        else $error("last band closed before issue finished");

    // base row stays inside the ring during a sweep
    a_base_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (32'(r_base) < 32'(i_rows)))
        else $error("base row outside ring");

    // every used ring read lands inside the ring
    a_row_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2.valid && r_s2.use_smp) |-> (32'(r_s2_row) < 32'(i_rows)))
        else $error("delayed row outside ring");

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for the sub-band dedispersion sum block: random and directed beats checked
// against an in-bench prediction of every band sum, with idling on both channels
// depends on sds_pkg and subband_dedispersion_sum
`timescale 1ns / 1ps

module tb_top;
    import sds_pkg::*;

    localparam int N_CHAN        = NUM_CHANNELS_DEF;
    localparam int RING_MAX      = RING_DEPTH_DEF;
    localparam int BANDS_MAX     = MAX_BANDS_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CMD_W-1:0] OP_UNUSED = 2'd3;

    // one result beat as the block returns it
    typedef struct packed {
        logic [BAND_OUT_W-1:0] band;
        logic [SUM_W-1:0]      sum;
        logic                  last;
    } band_beat_t;

    // tracks ring contents, delays and registers, and holds the band sums still owed
    class band_sum_scoreboard;
        logic [VALUE_W-1:0] ring_sample [int];
        logic [ROW_W-1:0]   delay_rows [N_CHAN];
        bit                 chan_ignored [N_CHAN];
        int unsigned        read_row;
        int unsigned        nb_reg;
        int unsigned        cpb_reg;
        int unsigned        rr_reg;
        band_beat_t         expected_bands [$];
        int                 mismatches;

        function new();
            nb_reg     = 1;
            cpb_reg    = CPB_MAX;
            rr_reg     = RING_MAX;
            read_row   = 0;
            mismatches = 0;
            foreach (delay_rows[i]) begin
                delay_rows[i]   = '0;
                chan_ignored[i] = 1'b0;
            end
        endfunction

        function int unsigned eff_rows();
            return (rr_reg < 2) ? 2 : (rr_reg > RING_MAX) ? RING_MAX : rr_reg;
        endfunction

        function int unsigned eff_bands();
            return (nb_reg < 1) ? 1 : (nb_reg > BANDS_MAX) ? BANDS_MAX : nb_reg;
        endfunction

        function int unsigned eff_cpb();
            return (cpb_reg < 1) ? 1 : (cpb_reg > CPB_MAX) ? CPB_MAX : cpb_reg;
        endfunction

        // channels that a compute can touch under the current settings
        function int unsigned active_channels();
            int unsigned span;
            span = eff_bands() * eff_cpb();
            return (span > N_CHAN) ? N_CHAN : span;
        endfunction

        // ring row that the next compute reads for one channel
        function int unsigned sample_row(int unsigned chan);
            int unsigned rows;
            int unsigned d;
            rows = eff_rows();
            d = delay_rows[chan];
            if (d > rows - 1) d = rows - 1;
            return (read_row % rows + d) % rows;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NUM_BANDS: nb_reg  = data[NB_W-1:0];
                CFG_CPB:       cpb_reg = data[CPB_REG_W-1:0];
                CFG_RING_ROWS: rr_reg  = data[RR_W-1:0];
                default: ;
            endcase
        endfunction

        // apply one accepted input beat and queue the band sums it causes
        function void note_beat(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                logic [CHAN_W-1:0] chan, logic [VALUE_W-1:0] value,
                                logic ign);
            int unsigned rows;
            int unsigned nb;
            int unsigned cpb;
            int unsigned c;
            int unsigned key;
            longint unsigned acc;
            band_beat_t beat;
            rows = eff_rows();
            nb   = eff_bands();
            cpb  = eff_cpb();
            case (cmd)
                OP_WRITE: begin
                    // rows beyond the ring are dropped
                    if (int'(row) < rows) ring_sample[int'(row) * N_CHAN + int'(chan)] = value;
                end
                OP_LOAD: begin
                    delay_rows[chan]   = (value > RING_MAX - 1) ? ROW_W'(RING_MAX - 1)
                                                                : value[ROW_W-1:0];
                    chan_ignored[chan] = ign;
                end
                OP_COMPUTE: begin
                    for (int unsigned b = 0; b < nb; b++) begin
                        acc = 0;
                        for (int unsigned k = 0; k < cpb; k++) begin
                            c = b * cpb + k;
                            if (c < N_CHAN && !chan_ignored[c]) begin
                                key = sample_row(c) * N_CHAN + c;
                                if (ring_sample.exists(key)) acc += ring_sample[key];
                            end
                        end
                        beat.band = BAND_OUT_W'(b);
                        beat.sum  = acc[SUM_W-1:0];
                        beat.last = (b + 1 == nb);
                        expected_bands.push_back(beat);
                    end
                    read_row = (read_row % rows + 1) % rows;
                end
                default: ;
            endcase
        endfunction

        // compare one accepted result beat with the oldest band sum owed
        function void check_band(logic [BAND_OUT_W-1:0] band, logic [SUM_W-1:0] sum,
                                 logic last);
            band_beat_t want;
            if (expected_bands.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: band %0d sum %0d last %0d",
                             band, sum, last);
            end else begin
                want = expected_bands.pop_front();
                if (want.band !== band || want.sum !== sum || want.last !== last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result mismatch: expected band %0d sum %0d last %0d, %s %0d %0d %0d",
                                 want.band, want.sum, want.last, "got band/sum/last",
                                 band, sum, last);
                end
            end
        endfunction
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    i_in_valid    = 1'b0;
    logic [CMD_W-1:0]        i_command     = '0;
    logic [ROW_W-1:0]        i_row         = '0;
    logic [CHAN_W-1:0]       i_channel     = '0;
    logic [VALUE_W-1:0]      i_value       = '0;
    logic                    i_ignore_flag = 1'b0;
    logic                    i_out_stall   = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [BAND_OUT_W-1:0]   o_band;
    logic [SUM_W-1:0]        o_band_sum;
    logic                    o_last;

    band_sum_scoreboard sb = new();
    int idle_pct   = 0;
    int stall_left = 0;

    subband_dedispersion_sum dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_channel    (i_channel),
        .i_value      (i_value),
        .i_ignore_flag(i_ignore_flag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_band       (o_band),
        .o_band_sum   (o_band_sum),
        .o_last       (o_last)
    );

    always #4 i_clk = ~i_clk;

    // result side: check accepted beats, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_band(o_band, o_band_sum, o_last);
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 999) < idle_pct * 3) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // present one input beat, hold it until taken, then note it
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                             input logic [CHAN_W-1:0] chan, input logic [VALUE_W-1:0] value,
                             input logic ign);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_row         <= row;
        i_channel     <= chan;
        i_value       <= value;
        i_ignore_flag <= ign;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(cmd, row, chan, value, ign);
    endtask

    // drop valid, wait for every owed band sum, then let queued beats drain
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (sb.expected_bands.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] nb,
                              input logic [CFG_DATA_W-1:0] cpb,
                              input logic [CFG_DATA_W-1:0] rr);
        logic [CFG_DATA_W-1:0] vals [3];
        t_cfg_idx idx;
        vals = '{nb, cpb, rr};
        for (int i = 0; i < 3; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idx, vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // write ring entries the next compute reads, if unwritten or all_max, then compute
    task automatic fill_and_compute(input bit all_max);
        int unsigned active;
        int unsigned r;
        active = sb.active_channels();
        for (int unsigned c = 0; c < active; c++) begin
            if (!sb.chan_ignored[c]) begin
                r = sb.sample_row(c);
                if (all_max || !sb.ring_sample.exists(r * N_CHAN + c))
                    send_beat(OP_WRITE, ROW_W'(r), CHAN_W'(c),
                              all_max ? '1 : pick_value(), 1'($urandom_range(0, 1)));
            end
        end
        send_beat(OP_COMPUTE, ROW_W'($urandom_range(0, 511)), CHAN_W'($urandom_range(0, 1023)),
                  VALUE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    endtask

    initial begin : stimulus
        int unsigned random_items;
        int unsigned rows;
        int unsigned active;
        int unsigned pick;
        int unsigned n;
        logic [CHAN_W-1:0]  chan_pick;
        logic [VALUE_W-1:0] delay_pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // directed: field extremes, dropped writes, large delay, ignore, unused command
        set_config(2, 3, 4);
        send_beat(OP_WRITE, 9'd0, 10'd0, 16'hFFFF, 1'b0);
        send_beat(OP_WRITE, 9'd3, 10'd1023, 16'h0000, 1'b1);
        send_beat(OP_WRITE, 9'd4, 10'd1, 16'h1234, 1'b0);
        send_beat(OP_WRITE, 9'd511, 10'd2, 16'hA5A5, 1'b0);
        send_beat(OP_LOAD, 9'd0, 10'd1, 16'hFFFF, 1'b0);
        send_beat(OP_LOAD, 9'd511, 10'd2, 16'd2, 1'b1);
        send_beat(OP_LOAD, 9'd0, 10'd1023, 16'd0, 1'b1);
        send_beat(OP_UNUSED, 9'h1FF, 10'h3FF, 16'hFFFF, 1'b1);
        repeat (3) fill_and_compute(1'b0);
        send_beat(OP_LOAD, 9'd0, 10'd2, 16'd1, 1'b0);
        fill_and_compute(1'b0);

        // register values above range, every channel at full scale in band 0
        settle_block();
        set_config(31, 2047, 1023);
        for (int ch = 0; ch < 8; ch++)
            send_beat(OP_LOAD, 9'd0, CHAN_W'(ch), VALUE_W'($urandom_range(0, 600)), 1'b0);
        send_beat(OP_LOAD, 9'd0, 10'd1023, 16'd0, 1'b0);
        fill_and_compute(1'b1);

        // register values below range
        settle_block();
        set_config(0, 0, 1);
        repeat (3) fill_and_compute(1'b0);

        // read row left beyond a ring that shrinks
        settle_block();
        set_config(1, 2, 16);
        while (sb.read_row < 9) fill_and_compute(1'b0);
        settle_block();
        set_config(1, 2, 4);
        repeat (2) fill_and_compute(1'b0);

        // random phases, mostly small settings; idling off towards the end
        random_items = 0;
        while (random_items < 170) begin
            settle_block();
            if (random_items >= 130) idle_pct = 0;
            else case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 30;
                default: idle_pct = 50;
            endcase
            set_config(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(2, 16));
            n = $urandom_range(12, 24);
            repeat (n) begin
                rows      = sb.eff_rows();
                active    = sb.active_channels();
                pick      = $urandom_range(0, 99);
                chan_pick = ($urandom_range(0, 9) < 7) ? CHAN_W'($urandom_range(0, active - 1))
                                                       : CHAN_W'($urandom_range(0, N_CHAN - 1));
                case ($urandom_range(0, 5))
                    0:       delay_pick = VALUE_W'($urandom_range(0, 65535));
                    1:       delay_pick = VALUE_W'($urandom_range(0, 511));
                    default: delay_pick = VALUE_W'($urandom_range(0, rows + 2));
                endcase
                if (pick < 40) begin
                    send_beat(OP_WRITE,
                              ($urandom_range(0, 4) != 0) ? ROW_W'($urandom_range(0, rows - 1))
                                                          : ROW_W'($urandom_range(0, 511)),
                              chan_pick, pick_value(), 1'($urandom_range(0, 1)));
                    random_items++;
                end else if (pick < 58) begin
                    send_beat(OP_LOAD, ROW_W'($urandom_range(0, 511)), chan_pick, delay_pick,
                              $urandom_range(0, 3) == 0);
                    random_items++;
                end else if (pick < 94) begin
                    fill_and_compute(1'b0);
                    random_items++;
                end else begin
                    send_beat(OP_UNUSED, ROW_W'($urandom_range(0, 511)), chan_pick,
                              pick_value(), 1'($urandom_range(0, 1)));
                end
            end
        end

        settle_block();
        if (sb.mismatches == 0 && sb.expected_bands.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
src/sds_pkg.sv
src/sds_front.sv
src/sds_queue.sv
src/sds_back.sv
src/subband_dedispersion_sum.sv
tb/tb_top.sv
